@@ rtl/m3i_pkg.sv @@
// shared constants for the 3x3 matrix inverse
`timescale 1ns / 1ps
package m3i_pkg;

    // elements in one matrix
    localparam int N_ELEM = 9;

    // determinant threshold register
    localparam int DET_THR_BITS = 31;
    localparam logic [DET_THR_BITS-1:0] DET_THR_RESET = 31'd1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // adjugate element k = m[a]*m[b] - m[c]*m[d], row-major indices
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage

@@ rtl/matrix3_inverse.sv @@
// Throughput: one matrix per cycle when the output side does not stall; each
// divide lane resolves one quotient bit per pipeline stage, WORD_BITS stages
// deep, nine lanes side by side.
// Reset (synchronous, active low) empties the pipelines and the queue and sets
// det_threshold to 1; the block accepts transfers in the cycle after reset.
`timescale 1ns / 1ps
module matrix3_inverse #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [((9*WORD_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    // tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [((9*WORD_BITS+7)/8)*8-1:0]    o_m_axis_tdata,
    // tuser: singular
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [m3i_pkg::DET_THR_BITS-1:0]    i_cfg_data
);
    import m3i_pkg::*;

    localparam int MW = N_ELEM * WORD_BITS;
    localparam int TW = ((9 * WORD_BITS + 7) / 8) * 8;
    localparam int EW = 30 * WORD_BITS + 10;

    logic [DET_THR_BITS-1:0] r_thr;
    logic                    q_push, q_full, q_pop, q_empty;
    logic [EW-1:0]           q_wdata, q_rdata;
    logic [MW-1:0]           out_mat;

    // threshold register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= DET_THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    m3i_front #(.W(WORD_BITS), .F(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_mat   (i_s_axis_tdata[MW-1:0]),
        .i_thr   (r_thr),
        .o_push  (q_push),
        .i_full  (q_full),
        .o_entry (q_wdata)
    );

    m3i_fifo #(.DW(EW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    m3i_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .o_pop   (q_pop),
        .i_entry (q_rdata),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_mat   (out_mat),
        .o_sing  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = TW'(out_mat);

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

@@ rtl/m3i_front.sv @@
// front end: accepts matrices, forms cofactors and determinant, classifies
`timescale 1ns / 1ps
module m3i_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [m3i_pkg::N_ELEM*W-1:0]      i_mat,
    input  logic [m3i_pkg::DET_THR_BITS-1:0]  i_thr,
    output logic                              o_push,
    input  logic                              i_full,
    output logic [30*W+9:0]                   o_entry
);
    import m3i_pkg::*;

    localparam int MW  = N_ELEM * W;
    localparam int ADW = 3 * W;
    localparam int CW  = (ADW > DET_THR_BITS + 2 * F) ? ADW : DET_THR_BITS + 2 * F;

    logic       adv;
    logic [6:0] r_v;

    logic [MW-1:0] r_mat0, r_mat1, r_mat2, r_mat3, r_mat4, r_mat5, r_mat6;
    logic signed [2*W-1:0] r_pp [2*N_ELEM];
    logic signed [2*W:0]   r_cof2 [N_ELEM];
    logic signed [2*W:0]   r_cof3 [N_ELEM];
    logic signed [2*W:0]   r_cof4 [N_ELEM];
    logic signed [2*W:0]   r_cof5 [N_ELEM];
    logic signed [2*W:0]   r_plo [3];
    logic signed [2*W:0]   r_phi [3];
    logic signed [3*W:0]   r_prod [3];
    logic signed [3*W:0]   r_det;
    logic [ADW-1:0]        r_adet;
    logic [2*W-1:0]        r_acof [N_ELEM];
    logic [N_ELEM-1:0]     r_neg;
    logic                  r_sing;

    logic signed [W-1:0] m0 [N_ELEM];
    logic signed [W-1:0] m2 [N_ELEM];
    logic [3*W:0]        det_mag;
    logic [ADW-1:0]      adet;

    // pipeline advances when the last stage is empty or the queue has room
    assign adv     = !r_v[6] || !i_full;
    assign o_ready = adv;
    assign o_push  = r_v[6] && !i_full;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N_ELEM; gi++) begin : g_elem
            assign m0[gi] = r_mat0[gi*W +: W];
            assign m2[gi] = r_mat2[gi*W +: W];
        end
    endgenerate

    // stage 0: input register, stage 1: pair products, stage 2: cofactors
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mat0 <= i_mat;
            r_mat1 <= r_mat0;
            r_mat2 <= r_mat1;
            for (int k = 0; k < N_ELEM; k++) begin
                r_pp[2*k]   <= m0[COF_IDX[k][0]] * m0[COF_IDX[k][1]];
                r_pp[2*k+1] <= m0[COF_IDX[k][2]] * m0[COF_IDX[k][3]];
                r_cof2[k]   <= {r_pp[2*k][2*W-1], r_pp[2*k]}
                             - {r_pp[2*k+1][2*W-1], r_pp[2*k+1]};
            end
        end
    end

    // stage 3: first row times first adjugate column, split in two halves
    // stage 4: halves combined, stage 5: determinant sum
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mat3 <= r_mat2;
            r_mat4 <= r_mat3;
            r_mat5 <= r_mat4;
            r_cof3 <= r_cof2;
            r_cof4 <= r_cof3;
            r_cof5 <= r_cof4;
            for (int j = 0; j < 3; j++) begin
                r_plo[j]  <= m2[j] * $signed({1'b0, r_cof2[3*j][W-1:0]});
                r_phi[j]  <= m2[j] * $signed(r_cof2[3*j][2*W:W]);
                r_prod[j] <= {r_phi[j], {W{1'b0}}} + {{W{r_plo[j][2*W]}}, r_plo[j]};
            end
            r_det <= r_prod[0] + r_prod[1] + r_prod[2];
        end
    end

    // magnitude of the determinant
    assign det_mag = r_det[3*W] ? (~r_det + 1'b1) : r_det;
    assign adet    = det_mag[ADW-1:0];

    // stage 6: magnitudes, quotient signs and singular check
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mat6 <= r_mat5;
            r_adet <= adet;
            r_sing <= (r_det == '0) || (CW'(adet) < (CW'(i_thr) << (2 * F)));
            for (int k = 0; k < N_ELEM; k++) begin
                r_acof[k] <= r_cof5[k][2*W] ? (2*W)'(-r_cof5[k]) : r_cof5[k][2*W-1:0];
                r_neg[k]  <= r_cof5[k][2*W] ^ r_det[3*W];
            end
        end
    end

    // queue entry: neg bits, cofactor magnitudes, det magnitude, singular, matrix
    always_comb begin
        o_entry[N_ELEM-1:0] = r_neg;
        for (int k = 0; k < N_ELEM; k++) begin
            o_entry[N_ELEM + k*2*W +: 2*W] = r_acof[k];
        end
        o_entry[N_ELEM + 18*W +: ADW]      = r_adet;
        o_entry[N_ELEM + 21*W]             = r_sing;
        o_entry[N_ELEM + 21*W + 1 +: MW]   = r_mat6;
    end

endmodule

@@ rtl/m3i_fifo.sv @@
// short queue between the front end and the divide back end
`timescale 1ns / 1ps
module m3i_fifo #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [DW-1:0] o_data
);
    import m3i_pkg::*;

    logic [DW-1:0]               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]   r_wr, r_rd;
    logic [QUEUE_PTR_BITS:0]     r_cnt;

    assign o_full  = (r_cnt == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/m3i_div.sv @@
// one pipelined restoring divide lane, one quotient bit per stage, saturating
`timescale 1ns / 1ps
module m3i_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*W-1:0] i_num,
    input  logic [3*W-1:0] i_den,
    input  logic           i_neg,
    output logic [W-1:0]   o_quot
);
    localparam int NW  = 2 * W + 2 * F;
    localparam int ADW = 3 * W;
    localparam int XW  = ((NW > ADW + W) ? NW : ADW + W) + 1;

    logic [NW-1:0]  r_rem [W+1];
    logic [ADW-1:0] r_den [W+1];
    logic [W-1:0]   r_q   [W+1];
    logic [W:0]     r_neg;
    logic [W:0]     r_ovf;

    logic [NW-1:0] num_sh;
    logic [W-1:0]  lim;

    assign num_sh = {i_num, {(2*F){1'b0}}};

    // load: quotient overflows when the numerator reaches den * 2^W
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num_sh;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= XW'(num_sh) >= (XW'(i_den) << W);
        end
    end

    // quotient bit stages, msb first
    genvar gs;
    generate
        for (gs = 0; gs < W; gs++) begin : g_stage
            localparam int BIT = W - 1 - gs;
            logic [XW-1:0] sub;
            logic          take;
            assign sub  = XW'(r_den[gs]) << BIT;
            assign take = XW'(r_rem[gs]) >= sub;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gs+1]   <= take ? (r_rem[gs] - sub[NW-1:0]) : r_rem[gs];
                    r_den[gs+1]   <= r_den[gs];
                    r_q[gs+1]     <= r_q[gs] | (W'(take) << BIT);
                    r_neg[gs+1]   <= r_neg[gs];
                    r_ovf[gs+1]   <= r_ovf[gs];
                end
            end
        end
    endgenerate

    // sign and saturation to the word range
    assign lim = W'(1) << (W - 1);
    always_comb begin
        if (r_neg[W]) begin
            if (r_ovf[W] || r_q[W] > lim) begin
                o_quot = lim;
            end else begin
                o_quot = -r_q[W];
            end
        end else begin
            if (r_ovf[W] || r_q[W] >= lim) begin
                o_quot = lim - 1'b1;
            end else begin
                o_quot = r_q[W];
            end
        end
    end

endmodule

@@ rtl/m3i_back.sv @@
// back end: nine divide lanes, singular bypass and output register
`timescale 1ns / 1ps
module m3i_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  logic [30*W+9:0]               i_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [m3i_pkg::N_ELEM*W-1:0]  o_mat,
    output logic                          o_sing
);
    import m3i_pkg::*;

    localparam int MW  = N_ELEM * W;
    localparam int ADW = 3 * W;

    logic          out_free, adv;
    logic [W:0]    r_bv;
    logic [W:0]    r_sing;
    logic [MW-1:0] r_mat [W+1];
    logic [MW-1:0] quot;
    logic          r_ovalid;
    logic [MW-1:0] r_omat;
    logic          r_osing;

    // stall only when a finished result cannot move to the output register
    assign out_free = !r_ovalid || i_ready;
    assign adv      = !r_bv[W] || out_free;
    assign o_pop    = i_valid && adv;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (adv) begin
            r_bv <= {r_bv[W-1:0], i_valid};
        end
    end

    // matrix and singular flag ride along with the lanes
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mat[0]  <= i_entry[N_ELEM + 21*W + 1 +: MW];
            r_sing[0] <= i_entry[N_ELEM + 21*W];
            for (int s = 0; s < W; s++) begin
                r_mat[s+1]  <= r_mat[s];
                r_sing[s+1] <= r_sing[s];
            end
        end
    end

    // divide lanes
    genvar gk;
    generate
        for (gk = 0; gk < N_ELEM; gk++) begin : g_lane
            m3i_div #(.W(W), .F(F)) u_div (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_num  (i_entry[N_ELEM + gk*2*W +: 2*W]),
                .i_den  (i_entry[N_ELEM + 18*W +: ADW]),
                .i_neg  (i_entry[gk]),
                .o_quot (quot[gk*W +: W])
            );
        end
    endgenerate

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= r_bv[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_omat  <= r_sing[W] ? r_mat[W] : quot;
            r_osing <= r_sing[W];
        end
    end

    assign o_valid = r_ovalid;
    assign o_mat   = r_omat;
    assign o_sing  = r_osing;

endmodule

@@ verif/matrix3_inverse_checker.sv @@
// checker for the 3x3 matrix inverse: watches all channels, predicts and compares results
`timescale 1ns / 1ps
module matrix3_inverse_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [287:0] i_s_data,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [287:0] i_m_data,
    input  logic         i_m_user,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [30:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_singular_seen,
    output int           o_inverted_seen
);

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [287:0] elems;
        logic         singular;
    } inverse_t;

    inverse_t   inverse_q[$];
    logic [30:0] det_thr;

    // truncated, saturated quotient of a cofactor (2F fraction bits) by det (3F)
    function automatic logic [31:0] cof_quotient(wide_t cof, wide_t det);
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] quo;
        logic         neg;
        neg = cof[127] ^ det[127];
        num = {64'd0, (cof[127] ? -cof : cof)} << 32;
        den = {64'd0, (det[127] ? -det : det)};
        quo = num / den;
        if (neg) begin
            if (quo > 192'h8000_0000) quo = 192'h8000_0000;
            return -quo[31:0];
        end
        if (quo > 192'h7fff_ffff) quo = 192'h7fff_ffff;
        return quo[31:0];
    endfunction

    // expected inverse of one matrix under the current threshold
    function automatic inverse_t predict_inverse(logic [287:0] mat, logic [30:0] thr);
        wide_t        e [9];
        wide_t        det;
        wide_t        adj [9];
        logic [127:0] mag;
        logic [127:0] lim;
        inverse_t     res;
        for (int i = 0; i < 9; i++) e[i] = $signed(mat[32*i +: 32]);
        det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
            - e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[0]*e[5]*e[7];
        mag = det[127] ? -det : det;
        lim = {97'd0, thr} << 32;
        if (det == 0 || mag < lim) begin
            res.elems = mat;
            res.singular = 1'b1;
            return res;
        end
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        for (int i = 0; i < 9; i++) res.elems[32*i +: 32] = cof_quotient(adj[i], det);
        res.singular = 1'b0;
        return res;
    endfunction

    assign o_pending = inverse_q.size();

    // track register, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        inverse_t want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            det_thr <= 31'd1;
            o_fail_count <= 0;
            o_singular_seen <= 0;
            o_inverted_seen <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) det_thr <= i_cfg_data;
            if (i_s_valid && i_s_ready) inverse_q.push_back(predict_inverse(i_s_data, det_thr));
            if (i_m_valid && i_m_ready) begin
                if (inverse_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    errs++;
                end else begin
                    want = inverse_q.pop_front();
                    if (i_m_user) o_singular_seen <= o_singular_seen + 1;
                    else o_inverted_seen <= o_inverted_seen + 1;
                    for (int i = 0; i < 9; i++) begin
                        if (i_m_data[32*i +: 32] !== want.elems[32*i +: 32]) begin
                            $error("field out_m%0d%0d: expected %h, actual %h", i / 3, i % 3,
                                   want.elems[32*i +: 32], i_m_data[32*i +: 32]);
                            errs++;
                        end
                    end
                    if (i_m_user !== want.singular) begin
                        $error("field singular: expected %b, actual %b",
                               want.singular, i_m_user);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

@@ verif/matrix3_inverse_tb.sv @@
// stimulus and verdict for the 3x3 matrix inverse
`timescale 1ns / 1ps
module matrix3_inverse_tb;

    localparam int ONE = 32'h0001_0000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [287:0] s_data;
    logic         m_valid;
    logic         m_ready;
    logic [287:0] m_data;
    logic         m_user;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [30:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           singular_seen;
    int           inverted_seen;
    bit           no_idle;
    int           items_sent;
    int           cfg_writes;

    matrix3_inverse u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    matrix3_inverse_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (s_valid),
        .i_s_ready      (s_ready),
        .i_s_data       (s_data),
        .i_m_valid      (m_valid),
        .i_m_ready      (m_ready),
        .i_m_data       (m_data),
        .i_m_user       (m_user),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_singular_seen(singular_seen),
        .o_inverted_seen(inverted_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // time limit
    initial begin
        #4_000_000;
        $display("matrix3_inverse: mismatch");
        $finish;
    end

    // receiver stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_ready = no_idle || ($urandom_range(99) >= 33);
        end
    end

    // one matrix transfer; valid is left high for the caller
    task automatic send_matrix(logic [287:0] mat);
        if (!no_idle && $urandom_range(99) < 33) begin
            s_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data = mat;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // drain results, then write the threshold register
    task automatic write_threshold(logic [30:0] thr);
        s_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = thr;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [287:0] pack9(int a0, int a1, int a2, int a3, int a4,
                                           int a5, int a6, int a7, int a8);
        return {a8[31:0], a7[31:0], a6[31:0], a5[31:0], a4[31:0],
                a3[31:0], a2[31:0], a1[31:0], a0[31:0]};
    endfunction

    // random matrix: full range, small values or diagonally heavy
    function automatic logic [287:0] rand_matrix();
        logic [287:0] mat;
        int           mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 9; i++) begin
            if (mode < 3) mat[32*i +: 32] = $urandom;
            else mat[32*i +: 32] = int'($urandom_range(8 * ONE)) - 4 * ONE;
            if (mode >= 7 && i % 4 == 0)
                mat[32*i +: 32] = mat[32*i +: 32] + (($urandom_range(1)) ? 16 * ONE : -16 * ONE);
        end
        return mat;
    endfunction

    task automatic run_directed();
        send_matrix(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_matrix(pack9(2*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, -ONE/2));
        send_matrix(pack9(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
        send_matrix(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(pack9(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE));
        send_matrix(pack9(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff));
        send_matrix(pack9(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000));
        send_matrix(pack9(32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff));
        send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, 1));
        send_matrix(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, -1));
        send_matrix(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
        send_matrix(pack9(32'h80000000, 32'h7fffffff, 1, -1, 32'h80000000, 3*ONE,
                          ONE, -ONE, 32'h7fffffff));
        send_matrix(pack9(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    endtask

    initial begin
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        no_idle = 1'b0;
        items_sent = 0;
        cfg_writes = 0;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset threshold, then zero, then the largest, then a middle one
        run_directed();
        write_threshold(31'd0);
        run_directed();
        write_threshold(31'h7fffffff);
        run_directed();
        for (int i = 0; i < 20; i++) send_matrix(rand_matrix());
        write_threshold(31'h0000_8000);
        run_directed();

        // random part with threshold changes and one stretch of no idling
        for (int i = 0; i < 460; i++) begin
            if (i == 150) write_threshold(31'd1);
            if (i == 300) write_threshold(31'd0);
            if (i == 400) write_threshold(31'h0004_0000);
            no_idle = (i >= 200 && i < 280);
            if (i % 50 == 25) write_threshold(31'($urandom_range(ONE)));
            send_matrix(rand_matrix());
        end
        s_valid = 1'b0;
        no_idle = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("covered %0d matrices and %0d threshold writes", items_sent, cfg_writes);
        $display("results: %0d inverted, %0d singular", inverted_seen, singular_seen);
        if (fail_count == 0) begin
            $display("matrix3_inverse: match");
        end else begin
            $display("matrix3_inverse: mismatch");
        end
        $finish;
    end

endmodule
